// ----- design/ubt_pkg.sv -----
`default_nettype none

package ubt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] OP_BIND       = 2'd0;
  localparam logic [1:0] OP_UNBIND     = 2'd1;
  localparam logic [1:0] OP_UNBIND_EFF = 2'd2;
  localparam logic [1:0] OP_FIND       = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_BOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [ID_BITS-1:0] entity_id;
    logic [ID_BITS-1:0] effect_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_BITS-1:0] result_entity;
    logic [ID_BITS-1:0] result_effect;
  } rsp_t;

  typedef struct packed {
    logic               used;
    logic [ID_BITS-1:0] entity;
    logic [ID_BITS-1:0] effect;
  } slot_t;

  typedef struct packed {
    logic               en;
    logic               set;
    logic [IDX_W-1:0]   idx;
    logic [ID_BITS-1:0] entity;
    logic [ID_BITS-1:0] effect;
  } slot_wr_t;

endpackage

`default_nettype wire

// ----- design/unique_binding_table.sv -----
// One-to-one table of (entity, effect) pairs with 16 slots, cleared at reset.
// A command is taken when start is high and busy is low. Every command walks
// all slots through one shared compare unit, one slot per clock, then commits
// at most one slot update in the commit state that registers the response.
// busy drops on the cycle the response is shown, and a new command is only
// taken once busy is low. rsp_valid_o is high for exactly one cycle; the
// response must be captured then, since the receiver cannot stall the block.
`default_nettype none

module unique_binding_table (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire ubt_pkg::cmd_t cmd_i,
  output logic         rsp_valid_o,
  output ubt_pkg::rsp_t rsp_o
);

  logic [ubt_pkg::IDX_W-1:0] rd_idx;
  ubt_pkg::slot_t            rd_slot;
  ubt_pkg::slot_wr_t         wr;

  ubt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .rd_idx_o    (rd_idx),
    .rd_slot_i   (rd_slot),
    .wr_o        (wr)
  );

  ubt_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_slot_o (rd_slot),
    .wr_i      (wr)
  );

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_rsp_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(busy))
    else $error("response without a command in flight");

  a_rsp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("response strobe longer than one cycle");

  a_write_in_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> rsp_valid_o)
    else $error("slot update outside commit");

  a_entity_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.result_entity != '0) |-> rsp_o.status == ubt_pkg::ST_OK)
    else $error("entity returned with error status");

endmodule

`default_nettype wire

// ----- design/ubt_store.sv -----
`default_nettype none

module ubt_store (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [ubt_pkg::IDX_W-1:0] rd_idx_i,
  output ubt_pkg::slot_t                rd_slot_o,
  input  wire ubt_pkg::slot_wr_t        wr_i
);

  logic [ubt_pkg::TABLE_DEPTH-1:0] used_q;
  logic [ubt_pkg::ID_BITS-1:0]     entity_q [ubt_pkg::TABLE_DEPTH];
  logic [ubt_pkg::ID_BITS-1:0]     effect_q [ubt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.en) begin
      used_q[wr_i.idx] <= wr_i.set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.set) begin
      entity_q[wr_i.idx] <= wr_i.entity;
      effect_q[wr_i.idx] <= wr_i.effect;
    end
  end

  assign rd_slot_o.used   = used_q[rd_idx_i];
  assign rd_slot_o.entity = entity_q[rd_idx_i];
  assign rd_slot_o.effect = effect_q[rd_idx_i];

endmodule

`default_nettype wire

// ----- design/ubt_seq.sv -----
`default_nettype none

module ubt_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire ubt_pkg::cmd_t             cmd_i,
  output logic                           rsp_valid_o,
  output ubt_pkg::rsp_t                  rsp_o,
  output logic [ubt_pkg::IDX_W-1:0]      rd_idx_o,
  input  wire ubt_pkg::slot_t            rd_slot_i,
  output ubt_pkg::slot_wr_t              wr_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [ubt_pkg::IDX_W-1:0]    idx_q;
  ubt_pkg::cmd_t                cmd_q;
  logic                         ent_hit_q, eff_hit_q, free_hit_q, hit_q;
  logic [ubt_pkg::IDX_W-1:0]    hit_idx_q, free_idx_q;
  logic [ubt_pkg::ID_BITS-1:0]  hit_eff_q;
  logic                         rsp_valid_q;
  ubt_pkg::rsp_t                rsp_q;

  logic ent_m, eff_m, key_m, ent_zero, eff_zero;
  ubt_pkg::rsp_t     rsp_d;
  ubt_pkg::slot_wr_t wr_d;

  // shared compare unit: one slot per cycle
  assign ent_m    = rd_slot_i.used && (rd_slot_i.entity == cmd_q.entity_id);
  assign eff_m    = rd_slot_i.used && (rd_slot_i.effect == cmd_q.effect_id);
  assign ent_zero = (cmd_q.entity_id == '0);
  assign eff_zero = (cmd_q.effect_id == '0);

  always_comb begin
    case (cmd_q.opcode)
      ubt_pkg::OP_UNBIND:     key_m = ent_m && eff_m;
      ubt_pkg::OP_UNBIND_EFF: key_m = eff_m;
      default:                key_m = ent_m;
    endcase
  end

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = ubt_pkg::ST_OK;
    wr_d         = '0;
    wr_d.idx     = hit_idx_q;
    wr_d.entity  = cmd_q.entity_id;
    wr_d.effect  = cmd_q.effect_id;
    case (cmd_q.opcode)
      ubt_pkg::OP_BIND: begin
        if (ent_zero || eff_zero) begin
          rsp_d.status = ubt_pkg::ST_INVALID;
        end else if (ent_hit_q || eff_hit_q) begin
          rsp_d.status = ubt_pkg::ST_BOUND;
        end else if (!free_hit_q) begin
          rsp_d.status = ubt_pkg::ST_FULL;
        end else begin
          rsp_d.result_effect = cmd_q.effect_id;
          wr_d.en  = 1'b1;
          wr_d.set = 1'b1;
          wr_d.idx = free_idx_q;
        end
      end
      ubt_pkg::OP_UNBIND: begin
        if (ent_zero || eff_zero) begin
          rsp_d.status = ubt_pkg::ST_INVALID;
        end else if (!hit_q) begin
          rsp_d.status = ubt_pkg::ST_NOT_FOUND;
        end else begin
          wr_d.en = 1'b1;
        end
      end
      ubt_pkg::OP_UNBIND_EFF: begin
        if (eff_zero || !hit_q) begin
          rsp_d.status = ubt_pkg::ST_INVALID;
        end else begin
          wr_d.en = 1'b1;
        end
      end
      default: begin
        if (ent_zero) begin
          rsp_d.status = ubt_pkg::ST_INVALID;
        end else if (!hit_q) begin
          rsp_d.status = ubt_pkg::ST_NOT_FOUND;
        end else begin
          rsp_d.result_entity = cmd_q.entity_id;
          rsp_d.result_effect = hit_eff_q;
        end
      end
    endcase
    if (state_q != S_DONE) begin
      wr_d.en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      ent_hit_q   <= 1'b0;
      eff_hit_q   <= 1'b0;
      free_hit_q  <= 1'b0;
      hit_q       <= 1'b0;
      free_idx_q  <= '0;
      hit_idx_q   <= '0;
      hit_eff_q   <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q    <= S_SCAN;
            idx_q      <= '0;
            ent_hit_q  <= 1'b0;
            eff_hit_q  <= 1'b0;
            free_hit_q <= 1'b0;
            hit_q      <= 1'b0;
          end
        end
        S_SCAN: begin
          if (ent_m) ent_hit_q <= 1'b1;
          if (eff_m) eff_hit_q <= 1'b1;
          if (!rd_slot_i.used && !free_hit_q) begin
            free_hit_q <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (key_m && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q;
            hit_eff_q <= rd_slot_i.effect;
          end
          if (idx_q == ubt_pkg::LAST_IDX) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DONE: begin
          rsp_valid_q <= 1'b1;
          rsp_q       <= rsp_d;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q <= cmd_i;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign rd_idx_o    = idx_q;
  assign wr_o        = wr_d;

endmodule

`default_nettype wire

// ----- tb/sv/unique_binding_table_tb.sv -----
`default_nettype none

module unique_binding_table_tb;

  typedef logic [ubt_pkg::ID_BITS-1:0] id_t;

  localparam int unsigned RAND_ITEMS = 1950;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MODE_FILL = 0;
  localparam int unsigned MODE_DRAIN = 1;
  localparam int unsigned MODE_MIX = 2;
  localparam id_t ID_ALL1 = '1;

  typedef struct packed {
    ubt_pkg::cmd_t cmd;
    logic          typed;
    ubt_pkg::rsp_t rsp;
  } dir_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  ubt_pkg::cmd_t cmd_i;
  logic          rsp_valid_o;
  ubt_pkg::rsp_t rsp_o;

  logic bound_used [ubt_pkg::TABLE_DEPTH];
  id_t  bound_ent  [ubt_pkg::TABLE_DEPTH];
  id_t  bound_eff  [ubt_pkg::TABLE_DEPTH];

  ubt_pkg::rsp_t pending_rsp_q [$];
  dir_row_t      dir_rows [$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   cycle_cnt = 0;

  unique_binding_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Shadow table: one command in, one response out, same scan rules as the block.
  function automatic ubt_pkg::rsp_t table_apply(ubt_pkg::cmd_t c);
    ubt_pkg::rsp_t r;
    int            hit;
    r = '0;
    r.status = ubt_pkg::ST_OK;
    hit = -1;
    case (c.opcode)
      ubt_pkg::OP_BIND: begin
        if (c.entity_id == '0 || c.effect_id == '0) begin
          r.status = ubt_pkg::ST_INVALID;
        end else begin
          for (int i = 0; i < int'(ubt_pkg::TABLE_DEPTH); i++)
            if (bound_used[i] && (bound_ent[i] == c.entity_id || bound_eff[i] == c.effect_id))
              hit = i;
          if (hit >= 0) begin
            r.status = ubt_pkg::ST_BOUND;
          end else begin
            for (int i = int'(ubt_pkg::TABLE_DEPTH) - 1; i >= 0; i--)
              if (!bound_used[i]) hit = i;
            if (hit < 0) begin
              r.status = ubt_pkg::ST_FULL;
            end else begin
              bound_used[hit] = 1'b1;
              bound_ent[hit] = c.entity_id;
              bound_eff[hit] = c.effect_id;
              r.result_effect = c.effect_id;
            end
          end
        end
      end
      ubt_pkg::OP_UNBIND: begin
        if (c.entity_id == '0 || c.effect_id == '0) begin
          r.status = ubt_pkg::ST_INVALID;
        end else begin
          for (int i = int'(ubt_pkg::TABLE_DEPTH) - 1; i >= 0; i--)
            if (bound_used[i] && bound_ent[i] == c.entity_id && bound_eff[i] == c.effect_id)
              hit = i;
          if (hit < 0) begin
            r.status = ubt_pkg::ST_NOT_FOUND;
          end else begin
            bound_used[hit] = 1'b0;
            bound_ent[hit] = '0;
            bound_eff[hit] = '0;
          end
        end
      end
      ubt_pkg::OP_UNBIND_EFF: begin
        if (c.effect_id != '0)
          for (int i = int'(ubt_pkg::TABLE_DEPTH) - 1; i >= 0; i--)
            if (bound_used[i] && bound_eff[i] == c.effect_id) hit = i;
        if (hit < 0) begin
          r.status = ubt_pkg::ST_INVALID;
        end else begin
          bound_used[hit] = 1'b0;
          bound_ent[hit] = '0;
          bound_eff[hit] = '0;
        end
      end
      default: begin
        if (c.entity_id == '0) begin
          r.status = ubt_pkg::ST_INVALID;
        end else begin
          for (int i = int'(ubt_pkg::TABLE_DEPTH) - 1; i >= 0; i--)
            if (bound_used[i] && bound_ent[i] == c.entity_id) hit = i;
          if (hit < 0) begin
            r.status = ubt_pkg::ST_NOT_FOUND;
          end else begin
            r.result_entity = bound_ent[hit];
            r.result_effect = bound_eff[hit];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_slot();
    int hits [$];
    for (int i = 0; i < int'(ubt_pkg::TABLE_DEPTH); i++)
      if (bound_used[i]) hits = {hits, i};
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  function automatic id_t pick_id(bit want_eff);
    int unsigned r;
    int          k;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 8) return ID_ALL1;
    if (r < 28) begin
      k = pick_slot();
      if (k >= 0) return want_eff ? bound_eff[k] : bound_ent[k];
    end
    if (r < 70) return id_t'($urandom_range(1, 40));
    return id_t'($urandom);
  endfunction

  function automatic ubt_pkg::cmd_t gen_cmd(int unsigned mode);
    ubt_pkg::cmd_t c;
    int unsigned   r;
    int            k;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL:  c.opcode = (r < 70) ? ubt_pkg::OP_BIND : 2'($urandom_range(3));
      MODE_DRAIN: c.opcode = (r < 30) ? ubt_pkg::OP_UNBIND :
                             (r < 60) ? ubt_pkg::OP_UNBIND_EFF :
                             (r < 80) ? ubt_pkg::OP_FIND : ubt_pkg::OP_BIND;
      default:    c.opcode = 2'($urandom_range(3));
    endcase
    c.entity_id = pick_id(1'b0);
    c.effect_id = pick_id(1'b1);
    k = pick_slot();
    // mostly hit live entries so unbind and find get past the lookup
    if (k >= 0 && c.opcode != ubt_pkg::OP_BIND && $urandom_range(99) < 60) begin
      if (c.opcode != ubt_pkg::OP_UNBIND_EFF) c.entity_id = bound_ent[k];
      if (c.opcode != ubt_pkg::OP_FIND) c.effect_id = bound_eff[k];
    end
    return c;
  endfunction

  task automatic add_row(logic [1:0] op, id_t ent, id_t eff,
                         logic typed, logic [2:0] st, id_t r_ent, id_t r_eff);
    dir_row_t row;
    row.cmd = '{opcode: op, entity_id: ent, effect_id: eff};
    row.typed = typed;
    row.rsp = '{status: st, result_entity: r_ent, result_effect: r_eff};
    dir_rows = {dir_rows, row};
  endtask

  // Entered and left on a clock edge; returns on the edge of the transfer.
  task automatic send_cmd(ubt_pkg::cmd_t c, logic typed, ubt_pkg::rsp_t typed_rsp,
                          bit idle_ok);
    ubt_pkg::rsp_t p;
    int unsigned   gap;
    if (idle_ok && $urandom_range(99) < 14) begin
      gap = $urandom_range(1, 24);
      repeat (gap) begin
        start <= 1'b0;
        cmd_i <= ubt_pkg::cmd_t'({2'($urandom_range(3)), $urandom, $urandom});
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = table_apply(c);
    pending_rsp_q = {pending_rsp_q, (typed ? typed_rsp : p)};
  endtask

  task automatic drain_rsp();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : rsp_chk
    ubt_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected response status=%0d entity=%h effect=%h",
                 $time, rsp_o.status, rsp_o.result_entity, rsp_o.result_effect);
        mismatch_cnt++;
      end else begin
        want = pending_rsp_q.pop_front();
        if (rsp_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_o.status);
          mismatch_cnt++;
        end
        if (rsp_o.result_entity !== want.result_entity) begin
          $display("%0t: result_entity expected %h actual %h",
                   $time, want.result_entity, rsp_o.result_entity);
          mismatch_cnt++;
        end
        if (rsp_o.result_effect !== want.result_effect) begin
          $display("%0t: result_effect expected %h actual %h",
                   $time, want.result_effect, rsp_o.result_effect);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d responses outstanding", $time, pending_rsp_q.size());
      $display("unique_binding_table regression: fail");
      $finish;
    end
  end

  initial begin : stim
    int unsigned mode;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    mode = MODE_MIX;
    for (int i = 0; i < int'(ubt_pkg::TABLE_DEPTH); i++) begin
      bound_used[i] = 1'b0;
      bound_ent[i] = '0;
      bound_eff[i] = '0;
    end

    add_row(ubt_pkg::OP_FIND,       32'd1,        32'd0,        1'b1,
            ubt_pkg::ST_NOT_FOUND, '0, '0);
    add_row(ubt_pkg::OP_BIND,       32'd0,        32'd5,        1'b1,
            ubt_pkg::ST_INVALID, '0, '0);
    add_row(ubt_pkg::OP_BIND,       32'd5,        32'd0,        1'b1,
            ubt_pkg::ST_INVALID, '0, '0);
    add_row(ubt_pkg::OP_UNBIND,     32'd0,        32'd5,        1'b1,
            ubt_pkg::ST_INVALID, '0, '0);
    add_row(ubt_pkg::OP_UNBIND_EFF, ID_ALL1,      32'd0,        1'b1,
            ubt_pkg::ST_INVALID, '0, '0);
    add_row(ubt_pkg::OP_FIND,       32'd0,        ID_ALL1,      1'b1,
            ubt_pkg::ST_INVALID, '0, '0);
    add_row(ubt_pkg::OP_BIND,       ID_ALL1,      ID_ALL1,      1'b1,
            ubt_pkg::ST_OK, '0, ID_ALL1);
    add_row(ubt_pkg::OP_FIND,       ID_ALL1,      32'd0,        1'b1,
            ubt_pkg::ST_OK, ID_ALL1, ID_ALL1);
    add_row(ubt_pkg::OP_BIND,       ID_ALL1,      32'd7,        1'b1,
            ubt_pkg::ST_BOUND, '0, '0);
    add_row(ubt_pkg::OP_BIND,       32'd7,        ID_ALL1,      1'b1,
            ubt_pkg::ST_BOUND, '0, '0);
    add_row(ubt_pkg::OP_UNBIND,     ID_ALL1,      32'd7,        1'b1,
            ubt_pkg::ST_NOT_FOUND, '0, '0);
    // unbind by effect reports a miss as invalid argument
    add_row(ubt_pkg::OP_UNBIND_EFF, 32'd0,        32'd7,        1'b1,
            ubt_pkg::ST_INVALID, '0, '0);
    add_row(ubt_pkg::OP_BIND,       32'd1,        32'd2,        1'b1,
            ubt_pkg::ST_OK, '0, 32'd2);
    add_row(ubt_pkg::OP_BIND,       32'd2,        32'd1,        1'b1,
            ubt_pkg::ST_OK, '0, 32'd1);
    add_row(ubt_pkg::OP_FIND,       32'd2,        32'd0,        1'b1,
            ubt_pkg::ST_OK, 32'd2, 32'd1);
    add_row(ubt_pkg::OP_UNBIND_EFF, 32'd123,      32'd2,        1'b1,
            ubt_pkg::ST_OK, '0, '0);
    add_row(ubt_pkg::OP_FIND,       32'd1,        32'd0,        1'b1,
            ubt_pkg::ST_NOT_FOUND, '0, '0);
    add_row(ubt_pkg::OP_UNBIND,     ID_ALL1,      ID_ALL1,      1'b1,
            ubt_pkg::ST_OK, '0, '0);
    add_row(ubt_pkg::OP_BIND,       32'h80000000, 32'd1,        1'b1,
            ubt_pkg::ST_BOUND, '0, '0);
    // lands in the lowest free slot
    add_row(ubt_pkg::OP_BIND,       32'h80000000, 32'h80000000, 1'b1,
            ubt_pkg::ST_OK, '0, 32'h80000000);
    add_row(ubt_pkg::OP_UNBIND,     32'd2,        32'd1,        1'b1,
            ubt_pkg::ST_OK, '0, '0);
    add_row(ubt_pkg::OP_FIND,       32'h80000000, 32'd0,        1'b1,
            ubt_pkg::ST_OK, 32'h80000000, 32'h80000000);
    add_row(ubt_pkg::OP_BIND,       32'h55555555, 32'haaaaaaaa, 1'b0,
            ubt_pkg::ST_OK, '0, '0);
    add_row(ubt_pkg::OP_BIND,       32'haaaaaaaa, 32'h55555555, 1'b0,
            ubt_pkg::ST_OK, '0, '0);
    add_row(ubt_pkg::OP_UNBIND_EFF, 32'h0,        32'haaaaaaaa, 1'b0,
            ubt_pkg::ST_OK, '0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].rsp, 1'b1);
    drain_rsp();

    for (int n = 0; n < int'(RAND_ITEMS); n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      if (n == int'(RAND_ITEMS) / 2) drain_rsp();
      send_cmd(gen_cmd(mode), 1'b0, '0, !(n >= 600 && n < 900));
    end

    drain_rsp();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("unique_binding_table regression: pass");
    end else begin
      $display("unique_binding_table regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/ubt_pkg.sv
design/ubt_store.sv
design/ubt_seq.sv
design/unique_binding_table.sv
tb/sv/unique_binding_table_tb.sv
